// File: src/fpi2d_pkg.sv
// Package for the 2-D Fourier point interpolator: sizes, codes and trig table.
package fpi2d_pkg;

  localparam int GridX      = 32;
  localparam int GridY      = 32;
  localparam int TrigDepth  = 1024;
  localparam int StoreDepth = GridX * GridY;
  localparam int IdxW       = $clog2(StoreDepth);
  localparam int IxW        = $clog2(GridX);
  localparam int IyW        = $clog2(GridY);
  localparam int TrigW      = $clog2(TrigDepth);
  localparam int CoefW      = 24;
  localparam int PointW     = 21;
  localparam int ProdW      = 49;
  localparam int AccW       = 64;
  localparam int SumW       = 40;
  localparam int MagW       = 48;
  localparam int SqSplitW   = 20;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_TAIL = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  typedef struct packed {
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] s;
  } trig_t;

  // Non-negative remainder of f*p modulo G*2^16, scaled to 32-bit turns.
  // G = 2^gw, so the modulo is a mask and the scale a left shift.
  function automatic logic [31:0] axis_turns(input logic signed [9:0] f,
                                             input logic [PointW-1:0] p,
                                             input int gw);
    logic signed [31:0] prod;
    logic [31:0] rem;
    begin
      prod = 32'(f) * $signed({1'b0, p});
      rem  = $unsigned(prod) & ((32'd1 << (16 + gw)) - 32'd1);
      axis_turns = rem << (16 - gw);
    end
  endfunction

  function automatic logic signed [CoefW-1:0] q30_to_q22(input logic signed [63:0] v);
    logic [63:0] u;
    begin
      u = (v < 0) ? 64'd0 : $unsigned(v);
      q30_to_q22 = CoefW'((u + 64'd128) >> 8);
    end
  endfunction

  function automatic trig_t trig_entry(input int k);
    logic [63:0] t, r, th, th2, st, ct;
    logic signed [63:0] s, c;
    logic [1:0] quad;
    logic signed [CoefW-1:0] cq, sq;
    trig_t e;
    begin
      t    = (64'(k) << 32) / 64'(TrigDepth);
      quad = t[31:30];
      r    = t & 64'h3FFF_FFFF;
      th   = (r * 64'd1686629713) >> 30;
      th2  = (th * th) >> 30;
      st   = th;
      ct   = 64'd1 << 30;
      s    = $signed(st);
      c    = $signed(ct);
      for (int n = 1; n <= 8; n++) begin
        st = ((st * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
        ct = ((ct * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          s = s - $signed(st);
          c = c - $signed(ct);
        end else begin
          s = s + $signed(st);
          c = c + $signed(ct);
        end
      end
      cq = q30_to_q22(c);
      sq = q30_to_q22(s);
      case (quad)
        2'd0:    begin e.c = cq;  e.s = sq;  end
        2'd1:    begin e.c = -sq; e.s = cq;  end
        2'd2:    begin e.c = -cq; e.s = -sq; end
        default: begin e.c = sq;  e.s = -cq; end
      endcase
      trig_entry = e;
    end
  endfunction

endpackage

// File: src/fpi2d_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module fpi2d_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/fourier_point_interpolator_2d_top.sv
// Top level of the 2-D Fourier point interpolator.
// Usage: raise start with in_* for one cycle while busy is low.
// A load transaction (in_req_type = 0) writes one coefficient and leaves busy low;
// an index beyond the table is ignored. No result is given for a load.
// An evaluate transaction (in_req_type = 1) walks all 1024 stored coefficients,
// one complex multiply-accumulate per cycle through a pipeline of phase,
// table/RAM read, multiply and accumulate stages, then scaling and a two-stage
// magnitude. The result is on out_* with out_valid high for one cycle, once the
// run, tail and output states are through. busy falls in that strobe cycle, so
// the next transaction can be taken at its closing edge. No new evaluation is
// taken until the last one is done; loads are taken one per cycle while busy is low.
// The receiver cannot stall; every result is taken in its strobe cycle.
// Reset (rst_n low, synchronous) returns control to idle; the coefficient
// store is not cleared and must be loaded before evaluating.
module fourier_point_interpolator_2d_top
  import fpi2d_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_req_type,
  input  logic [9:0]               in_coef_index,
  input  logic signed [CoefW-1:0]  in_coef_real,
  input  logic signed [CoefW-1:0]  in_coef_imag,
  input  logic [PointW-1:0]        in_point_x,
  input  logic [PointW-1:0]        in_point_y,
  output logic                     out_valid,
  output logic signed [SumW-1:0]   out_sum_real,
  output logic signed [SumW-1:0]   out_sum_imag,
  output logic [MagW-1:0]          out_magnitude_sq
);

  state_t state_r, state_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;
  logic [PointW-1:0] px_r, py_r;
  logic [3:0]      tail_r, tail_nxt;

  // stage valids
  logic v1_r, v2_r, v3_r;
  logic [31:0] ph1;
  logic [31:0] tx1_r, ty1_r;
  logic [IdxW-1:0] e1_r;
  trig_t trig2_r;
  trig_t trig_rom [TrigDepth];
  logic [2*CoefW-1:0] coef2;
  logic signed [ProdW-1:0] prr3_r, pii3_r, pri3_r, pir3_r;
  logic signed [AccW-1:0] accr_r, acci_r;
  logic signed [SumW-1:0] sr_r, si_r;
  logic [MagW-1:0] mag_r;
  logic out_valid_r;

  logic accept, issue;
  logic wr_en;
  logic [IxW-1:0] ix;
  logic [IyW-1:0] iy;
  logic signed [9:0] fx, fy;

  assign accept = start && !busy;
  assign wr_en  = accept && (in_req_type == REQ_LOAD) &&
                  ({1'b0, in_coef_index} < 11'(StoreDepth));
  assign issue  = (state_r == ST_RUN);
  assign ix = cnt_r[IdxW-1:IyW];
  assign iy = cnt_r[IyW-1:0];
  assign fx = (32'(ix) < GridX / 2) ? 10'(ix) : 10'(ix) - 10'(GridX);
  assign fy = (32'(iy) < GridY / 2) ? 10'(iy) : 10'(iy) - 10'(GridY);

  for (genvar k = 0; k < TrigDepth; k++) begin : g_trig
    assign trig_rom[k] = trig_entry(k);
  end

  fpi2d_ram #(.Width(2 * CoefW), .Depth(StoreDepth)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_coef_index[IdxW-1:0]),
    .wr_data ({in_coef_real, in_coef_imag}),
    .rd_addr (e1_r),
    .rd_data (coef2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    tail_nxt  = tail_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_EVAL) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IdxW'(StoreDepth - 1)) begin
          state_nxt = ST_TAIL;
          tail_nxt  = '0;
        end
      end
      ST_TAIL: begin
        tail_nxt = tail_r + 1'b1;
        if (tail_r == 4'd5) state_nxt = ST_OUT;
      end
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= issue; v2_r <= v1_r; v3_r <= v2_r;
      out_valid_r <= (state_r == ST_OUT);
    end
  end

  // stage 1: per-axis phase
  always_ff @(posedge clk) begin
    tx1_r <= axis_turns(fx, px_r, IxW);
    ty1_r <= axis_turns(fy, py_r, IyW);
    e1_r  <= cnt_r;
  end
  assign ph1 = tx1_r + ty1_r;

  // stage 2: table and store read
  always_ff @(posedge clk) begin
    trig2_r <= trig_rom[ph1[31 -: TrigW]];
  end

  // stage 3: products
  logic signed [CoefW-1:0] cr2, ci2;
  assign cr2 = coef2[2*CoefW-1:CoefW];
  assign ci2 = coef2[CoefW-1:0];
  always_ff @(posedge clk) begin
    prr3_r <= ProdW'(cr2) * ProdW'(trig2_r.c);
    pii3_r <= ProdW'(ci2) * ProdW'(trig2_r.s);
    pri3_r <= ProdW'(cr2) * ProdW'(trig2_r.s);
    pir3_r <= ProdW'(ci2) * ProdW'(trig2_r.c);
  end

  // stage 4: accumulate
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      accr_r <= '0;
      acci_r <= '0;
    end else if (v3_r) begin
      accr_r <= accr_r + AccW'(prr3_r) - AccW'(pii3_r);
      acci_r <= acci_r + AccW'(pri3_r) + AccW'(pir3_r);
    end
  end

  // final: floor shift, wrap, magnitude from split partial squares
  logic signed [AccW-1:0] shr, shi;
  logic [SumW-1:0] ar, ai;
  logic [SqSplitW-1:0] arh, arl, aih, ail;
  logic [2*SqSplitW-1:0] prhh_r, prhl_r, prll_r, pihh_r, pihl_r, pill_r;
  logic [2*SumW:0] tot;
  assign shr = accr_r >>> 22;
  assign shi = acci_r >>> 22;
  always_ff @(posedge clk) begin
    sr_r <= SumW'(shr);
    si_r <= SumW'(shi);
  end
  assign ar  = sr_r[SumW-1] ? SumW'(-sr_r) : sr_r;
  assign ai  = si_r[SumW-1] ? SumW'(-si_r) : si_r;
  assign arh = ar[SumW-1:SqSplitW];
  assign arl = ar[SqSplitW-1:0];
  assign aih = ai[SumW-1:SqSplitW];
  assign ail = ai[SqSplitW-1:0];
  always_ff @(posedge clk) begin
    prhh_r <= arh * arh;
    prhl_r <= arh * arl;
    prll_r <= arl * arl;
    pihh_r <= aih * aih;
    pihl_r <= aih * ail;
    pill_r <= ail * ail;
  end
  assign tot = (((2*SumW+1)'(prhh_r) + (2*SumW+1)'(pihh_r)) << (2*SqSplitW)) +
               (((2*SumW+1)'(prhl_r) + (2*SumW+1)'(pihl_r)) << (SqSplitW+1)) +
               (2*SumW+1)'(prll_r) + (2*SumW+1)'(pill_r);
  always_ff @(posedge clk) begin
    mag_r <= (|tot[2*SumW:MagW+22]) ? {MagW{1'b1}} : tot[MagW+21:22];
  end

  assign out_valid        = out_valid_r;
  assign out_sum_real     = sr_r;
  assign out_sum_imag     = si_r;
  assign out_magnitude_sq = mag_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> busy) else $error("busy low while running");
  a_out_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_OUT)) else $error("stray result");
  a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !issue) else $error("issue while idle");

endmodule
